@@ sv/krt_pkg.sv @@
// ----------------------------------------------------------------------------
// krt_pkg
// Shared types and codes for the keyed record table.
// ----------------------------------------------------------------------------
package krt_pkg;

  localparam int KEY_W    = 20;
  localparam int NAME_W   = 64;
  localparam int SCORE_W  = 10;
  localparam int REQ_W    = 2;
  localparam int STATUS_W = 2;
  localparam int ENTRY_W  = 7;

  // request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_LOOKUP = 2'd1,
    REQ_DELETE = 2'd2
  } req_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // request travelling down the cell chain; once hit is set the key, name
  // and score fields carry the matched record instead of the request
  typedef struct packed {
    logic [REQ_W-1:0]   req;
    logic [KEY_W-1:0]   key;
    logic [NAME_W-1:0]  name;
    logic [SCORE_W-1:0] score;
    logic               hit;
  } pkt_t;

endpackage

@@ sv/krt_cell.sv @@
// ----------------------------------------------------------------------------
// krt_cell
// One table slot: holds a record and one stage of the request chain.
// ----------------------------------------------------------------------------
module krt_cell import krt_pkg::*; #(
  parameter int IDX = 0,
  parameter int CW  = 7,
  parameter int NW  = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic [CW-1:0]      count,
  input  logic               pkt_v_i,
  input  pkt_t               pkt_i,
  output logic               pkt_v_o,
  output pkt_t               pkt_o,
  input  logic [KEY_W-1:0]   nb_key_i,
  input  logic [NW-1:0]      nb_name_i,
  input  logic [SCORE_W-1:0] nb_score_i,
  output logic [KEY_W-1:0]   key_o,
  output logic [NW-1:0]      name_o,
  output logic [SCORE_W-1:0] score_o
);

  localparam logic [CW-1:0] MY_IDX = CW'(IDX);

  logic               pkt_v_r;
  pkt_t               pkt_r;
  logic [KEY_W-1:0]   key_r;
  logic [NW-1:0]      name_r;
  logic [SCORE_W-1:0] score_r;

  logic occupied;
  logic search;
  logic match;
  logic shift;
  logic ins;

  // per-slot decisions for the request held here
  always_comb begin
    occupied = (MY_IDX < count);
    search   = (pkt_r.req == REQ_LOOKUP) || (pkt_r.req == REQ_DELETE);
    match    = pkt_v_r && search && !pkt_r.hit && occupied && (pkt_r.key == key_r);
    shift    = pkt_v_r && (pkt_r.req == REQ_DELETE) && (pkt_r.hit || match);
    ins      = pkt_v_r && (pkt_r.req == REQ_INSERT) && (count == MY_IDX);
  end

  // outgoing request: pick up this record on the first match
  always_comb begin
    pkt_o = pkt_r;
    if (match) begin
      pkt_o.hit   = 1'b1;
      pkt_o.key   = key_r;
      pkt_o.name  = NAME_W'(name_r);
      pkt_o.score = score_r;
    end
  end

  assign pkt_v_o = pkt_v_r;
  assign key_o   = key_r;
  assign name_o  = name_r;
  assign score_o = score_r;

  // chain stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pkt_v_r <= 1'b0;
    end else if (en) begin
      pkt_v_r <= pkt_v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pkt_r <= pkt_i;
    end
  end

  // record: append on insert, pull from upper neighbor behind a delete
  always_ff @(posedge clk) begin
    if (en) begin
      if (ins) begin
        key_r   <= pkt_r.key;
        name_r  <= pkt_r.name[NW-1:0];
        score_r <= pkt_r.score;
      end else if (shift) begin
        key_r   <= nb_key_i;
        name_r  <= nb_name_i;
        score_r <= nb_score_i;
      end
    end
  end

endmodule

@@ sv/krt_ctrl.sv @@
// ----------------------------------------------------------------------------
// krt_ctrl
// Request admission, record count and result register.
// ----------------------------------------------------------------------------
module krt_ctrl import krt_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int CW    = 7
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                exit_v,
  input  pkt_t                exit_pkt,
  output logic                en,
  output logic [CW-1:0]       count,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] out_status,
  output logic [KEY_W-1:0]    out_key_out,
  output logic [NAME_W-1:0]   out_name_out,
  output logic [SCORE_W-1:0]  out_score_out,
  output logic [ENTRY_W-1:0]  out_entries_now
);

  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic                busy_r, busy_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] status_r;
  logic [KEY_W-1:0]    key_r;
  logic [NAME_W-1:0]   name_r;
  logic [SCORE_W-1:0]  score_r;
  logic [CW-1:0]       cnt_out_r;
  logic [CW+ENTRY_W-1:0] cnt_ext;

  logic    accept;
  logic    cap;
  status_t st;
  logic [CW-1:0] new_count;

  assign accept = in_valid && !busy_r;
  assign cap    = exit_v && (!out_valid_r || !out_stall);
  assign en     = !(exit_v && out_valid_r && out_stall);

  // status and new count for the request leaving the chain
  always_comb begin
    st        = ST_MISS;
    new_count = count_r;
    case (exit_pkt.req)
      REQ_INSERT: begin
        if (count_r == FULL_CNT) begin
          st = ST_FULL;
        end else begin
          st        = ST_DONE;
          new_count = count_r + CW'(1);
        end
      end
      REQ_LOOKUP: begin
        st = exit_pkt.hit ? ST_DONE : ST_MISS;
      end
      REQ_DELETE: begin
        if (exit_pkt.hit) begin
          st        = ST_DONE;
          new_count = count_r - CW'(1);
        end
      end
      default: begin
        st = ST_MISS;
      end
    endcase
  end

  // control next state
  always_comb begin
    busy_nxt      = busy_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cap) begin
      busy_nxt      = 1'b0;
      count_nxt     = new_count;
      out_valid_nxt = 1'b1;
    end
    if (accept) begin
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cap) begin
      status_r  <= st;
      key_r     <= exit_pkt.hit ? exit_pkt.key   : '0;
      name_r    <= exit_pkt.hit ? exit_pkt.name  : '0;
      score_r   <= exit_pkt.hit ? exit_pkt.score : '0;
      cnt_out_r <= new_count;
    end
  end

  assign cnt_ext         = {{ENTRY_W{1'b0}}, cnt_out_r};
  assign in_stall        = busy_r;
  assign count           = count_r;
  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_key_out     = key_r;
  assign out_name_out    = name_r;
  assign out_score_out   = score_r;
  assign out_entries_now = cnt_ext[ENTRY_W-1:0];

endmodule

@@ sv/keyed_record_table.sv @@
// ----------------------------------------------------------------------------
// keyed_record_table
// Dense record table as a chain of slots with delete compaction.
// ----------------------------------------------------------------------------
//  Channel | Ports                                            | Handshake
//  --------+--------------------------------------------------+--------------
//  input   | in_req_type, in_key_in, in_name_in, in_score_in  | in_valid/in_stall
//  result  | out_status, out_key_out, out_name_out,           | out_valid/out_stall
//          | out_score_out, out_entries_now                   |
//
// Each request walks the chain of DEPTH slots, one slot a cycle while the
// chain is not frozen; the result is registered as it leaves the last slot,
// and the next request is taken only after that result is captured.
// A delete compacts the table as the request passes: the matching slot and
// all slots above it copy their upper neighbor. Reset clears only the count and
// control. A stalled result freezes the chain only when a request reaches the end.
// ----------------------------------------------------------------------------
module keyed_record_table import krt_pkg::*; #(
  parameter int DEPTH      = 64,
  parameter int NAME_BYTES = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [REQ_W-1:0]    in_req_type,
  input  logic [KEY_W-1:0]    in_key_in,
  input  logic [NAME_W-1:0]   in_name_in,
  input  logic [SCORE_W-1:0]  in_score_in,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] out_status,
  output logic [KEY_W-1:0]    out_key_out,
  output logic [NAME_W-1:0]   out_name_out,
  output logic [SCORE_W-1:0]  out_score_out,
  output logic [ENTRY_W-1:0]  out_entries_now
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int NW = NAME_BYTES * 8;

  logic          en;
  logic [CW-1:0] count;
  pkt_t          head_pkt;
  logic          head_v;

  pkt_t               link_pkt   [DEPTH];
  logic               link_v     [DEPTH];
  logic [KEY_W-1:0]   rec_key    [DEPTH];
  logic [NW-1:0]      rec_name   [DEPTH];
  logic [SCORE_W-1:0] rec_score  [DEPTH];

  // request entering the first slot
  assign head_v         = in_valid && !in_stall;
  assign head_pkt.req   = in_req_type;
  assign head_pkt.key   = in_key_in;
  assign head_pkt.name  = in_name_in;
  assign head_pkt.score = in_score_in;
  assign head_pkt.hit   = 1'b0;

  // slot chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic               v_in;
    pkt_t               p_in;
    logic [KEY_W-1:0]   nb_key;
    logic [NW-1:0]      nb_name;
    logic [SCORE_W-1:0] nb_score;

    if (i == 0) begin : g_head
      assign v_in = head_v;
      assign p_in = head_pkt;
    end else begin : g_link
      assign v_in = link_v[i-1];
      assign p_in = link_pkt[i-1];
    end

    if (i == DEPTH - 1) begin : g_top
      assign nb_key   = rec_key[i];
      assign nb_name  = rec_name[i];
      assign nb_score = rec_score[i];
    end else begin : g_mid
      assign nb_key   = rec_key[i+1];
      assign nb_name  = rec_name[i+1];
      assign nb_score = rec_score[i+1];
    end

    krt_cell #(
      .IDX (i),
      .CW  (CW),
      .NW  (NW)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .en         (en),
      .count      (count),
      .pkt_v_i    (v_in),
      .pkt_i      (p_in),
      .pkt_v_o    (link_v[i]),
      .pkt_o      (link_pkt[i]),
      .nb_key_i   (nb_key),
      .nb_name_i  (nb_name),
      .nb_score_i (nb_score),
      .key_o      (rec_key[i]),
      .name_o     (rec_name[i]),
      .score_o    (rec_score[i])
    );
  end

  // admission, count and result register
  krt_ctrl #(
    .DEPTH (DEPTH),
    .CW    (CW)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .exit_v          (link_v[DEPTH-1]),
    .exit_pkt        (link_pkt[DEPTH-1]),
    .en              (en),
    .count           (count),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_key_out     (out_key_out),
    .out_name_out    (out_name_out),
    .out_score_out   (out_score_out),
    .out_entries_now (out_entries_now)
  );

endmodule

@@ sv/krt_checker.sv @@
// ----------------------------------------------------------------------------
// krt_checker
// Port-level checks for the keyed record table, bound to the top level.
// ----------------------------------------------------------------------------
module krt_checker import krt_pkg::*; #(
  parameter int DEPTH = 64
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [STATUS_W-1:0] out_status,
  input logic [KEY_W-1:0]    out_key_out,
  input logic [NAME_W-1:0]   out_name_out,
  input logic [SCORE_W-1:0]  out_score_out,
  input logic [ENTRY_W-1:0]  out_entries_now
);

  localparam logic [ENTRY_W-1:0] FULL_CNT = ENTRY_W'(DEPTH);

  // a stalled result holds its status, key and entry count
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_key_out) && $stable(out_entries_now))
    else $error("stalled result changed");

  // one request at a time: a transfer closes the input
  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input open right after a transfer");

  // a full report only comes with a full table
  a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |-> out_entries_now == FULL_CNT)
    else $error("full status with table not full");

  // no record data unless a record was found or deleted
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_DONE) |->
      (out_key_out == '0) && (out_name_out == '0) && (out_score_out == '0))
    else $error("record data on a miss or full result");

endmodule

bind keyed_record_table krt_checker #(
  .DEPTH (DEPTH)
) u_krt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_status      (out_status),
  .out_key_out     (out_key_out),
  .out_name_out    (out_name_out),
  .out_score_out   (out_score_out),
  .out_entries_now (out_entries_now)
);

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the keyed record table. A shadow copy of the table
// predicts every result from the accepted requests. Results are compared
// field by field in order, under random gaps on both sides in two of three phases.
// ----------------------------------------------------------------------------
module tb_top;
  import krt_pkg::*;

  localparam int TB_DEPTH    = 64;
  localparam int TB_NAME_B   = 8;
  localparam int CYCLE_LIMIT = 500000;
  localparam int POOL_SIZE   = 12;
  localparam logic [NAME_W-1:0] NAME_KEEP = {NAME_W{1'b1}} >> (NAME_W - 8 * TB_NAME_B);
  // request type three is not a real command; the block reports a miss
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [REQ_W-1:0]   req;
    logic [KEY_W-1:0]   key;
    logic [NAME_W-1:0]  name;
    logic [SCORE_W-1:0] score;
  } table_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    key;
    logic [NAME_W-1:0]   name;
    logic [SCORE_W-1:0]  score;
    logic [ENTRY_W-1:0]  entries;
  } table_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [REQ_W-1:0]    in_req_type = '0;
  logic [KEY_W-1:0]    in_key_in = '0;
  logic [NAME_W-1:0]   in_name_in = '0;
  logic [SCORE_W-1:0]  in_score_in = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [KEY_W-1:0]    out_key_out;
  logic [NAME_W-1:0]   out_name_out;
  logic [SCORE_W-1:0]  out_score_out;
  logic [ENTRY_W-1:0]  out_entries_now;

  keyed_record_table #(
    .DEPTH      (TB_DEPTH),
    .NAME_BYTES (TB_NAME_B)
  ) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_key_in       (in_key_in),
    .in_name_in      (in_name_in),
    .in_score_in     (in_score_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_key_out     (out_key_out),
    .out_name_out    (out_name_out),
    .out_score_out   (out_score_out),
    .out_entries_now (out_entries_now)
  );

  always #2 clk = ~clk;

  // shadow table and bench bookkeeping
  logic [KEY_W-1:0]   shadow_key   [TB_DEPTH];
  logic [NAME_W-1:0]  shadow_name  [TB_DEPTH];
  logic [SCORE_W-1:0] shadow_score [TB_DEPTH];
  int                 shadow_count = 0;

  table_req_t    pending_reqs[$];
  table_result_t expected_results[$];
  logic [KEY_W-1:0] key_pool[POOL_SIZE];

  int errors       = 0;
  int items_sent   = 0;
  int total_items  = 0;
  int cycle_count  = 0;
  int send_idle_pct;
  int recv_stall_pct;

  // Apply one request to the shadow table and return the result it yields.
  function automatic table_result_t apply_request(table_req_t r);
    table_result_t res;
    int hit_idx;
    res = '0;
    hit_idx = -1;
    res.status = ST_MISS;
    case (r.req)
      REQ_INSERT: begin
        if (shadow_count >= TB_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          shadow_key[shadow_count]   = r.key;
          shadow_name[shadow_count]  = r.name & NAME_KEEP;
          shadow_score[shadow_count] = r.score;
          shadow_count++;
          res.status = ST_DONE;
        end
      end
      REQ_LOOKUP, REQ_DELETE: begin
        // lowest matching index wins on duplicate keys
        for (int i = 0; i < shadow_count; i++) begin
          if (hit_idx < 0 && shadow_key[i] == r.key) hit_idx = i;
        end
        if (hit_idx >= 0) begin
          res.status = ST_DONE;
          res.key    = shadow_key[hit_idx];
          res.name   = shadow_name[hit_idx];
          res.score  = shadow_score[hit_idx];
          if (r.req == REQ_DELETE) begin
            // close the gap behind the removed record
            for (int j = hit_idx; j + 1 < shadow_count; j++) begin
              shadow_key[j]   = shadow_key[j + 1];
              shadow_name[j]  = shadow_name[j + 1];
              shadow_score[j] = shadow_score[j + 1];
            end
            shadow_count--;
          end
        end
      end
      default: ;
    endcase
    res.entries = shadow_count[ENTRY_W-1:0];
    return res;
  endfunction

  task automatic check_field(string fname, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %h actual %h", $time, fname, exp_v, act_v);
      errors++;
    end
  endtask

  task automatic add_request(logic [REQ_W-1:0] req, logic [KEY_W-1:0] key,
                             logic [NAME_W-1:0] name, logic [SCORE_W-1:0] score);
    table_req_t r;
    r.req   = req;
    r.key   = key;
    r.name  = name;
    r.score = score;
    pending_reqs.push_back(r);
  endtask

  // Random request; mostly pooled keys so lookups and deletes tend to hit.
  task automatic add_random(int ins_pct, int look_pct, int del_pct);
    int pick;
    logic [REQ_W-1:0] req;
    logic [KEY_W-1:0] key;
    pick = $urandom_range(99);
    if (pick < ins_pct) req = REQ_INSERT;
    else if (pick < ins_pct + look_pct) req = REQ_LOOKUP;
    else if (pick < ins_pct + look_pct + del_pct) req = REQ_DELETE;
    else req = REQ_UNUSED;
    if ($urandom_range(99) < 85) key = key_pool[$urandom_range(POOL_SIZE - 1)];
    else key = KEY_W'($urandom());
    add_request(req, key, {$urandom(), $urandom()}, SCORE_W'($urandom_range(1023)));
  endtask

  // idle mix per third of the run
  always_comb begin
    if (items_sent < total_items / 3) begin
      send_idle_pct  = 14;
      recv_stall_pct = 77;
    end else if (items_sent < 2 * total_items / 3) begin
      send_idle_pct  = 77;
      recv_stall_pct = 14;
    end else begin
      send_idle_pct  = 0;
      recv_stall_pct = 0;
    end
  end

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid    <= 1'b1;
        in_req_type <= pending_reqs[0].req;
        in_key_in   <= pending_reqs[0].key;
        in_name_in  <= pending_reqs[0].name;
        in_score_in <= pending_reqs[0].score;
        pending_reqs.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result-side backpressure
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // monitor: predict on request transfer, check on result transfer
  always @(posedge clk) begin
    table_req_t    req_seen;
    table_result_t exp_r;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        req_seen.req   = in_req_type;
        req_seen.key   = in_key_in;
        req_seen.name  = in_name_in;
        req_seen.score = in_score_in;
        expected_results.push_back(apply_request(req_seen));
        items_sent++;
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: expected none actual status %h key %h",
                   $time, out_status, out_key_out);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("status",      64'(exp_r.status),  64'(out_status));
          check_field("key_out",     64'(exp_r.key),     64'(out_key_out));
          check_field("name_out",    exp_r.name,         out_name_out);
          check_field("score_out",   64'(exp_r.score),   64'(out_score_out));
          check_field("entries_now", 64'(exp_r.entries), 64'(out_entries_now));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** keyed_record_table: FAILED **");
      $finish;
    end
  end

  initial begin
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = KEY_W'($urandom());

    // directed: empty table, extremes, duplicates, compaction, unused type
    add_request(REQ_LOOKUP, 20'h00000, '0, '0);
    add_request(REQ_DELETE, 20'hFFFFF, '1, '1);
    add_request(REQ_UNUSED, 20'h12345, '1, '1);
    add_request(REQ_INSERT, 20'h00000, 64'h0, 10'h000);
    add_request(REQ_INSERT, 20'hFFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 10'h3FF);
    add_request(REQ_INSERT, 20'h12345, 64'h414C_5048_4131_2020, 10'h155);
    add_request(REQ_INSERT, 20'h12345, 64'h4245_5441_3232_2020, 10'h2AA);
    add_request(REQ_INSERT, 20'h00ABC, 64'h5245_434F_5244_5F33, 10'h001);
    add_request(REQ_LOOKUP, 20'hFFFFF, '0, '0);
    add_request(REQ_LOOKUP, 20'h12345, '0, '0);
    add_request(REQ_LOOKUP, 20'h54321, '0, '0);
    add_request(REQ_DELETE, 20'h12345, '0, '0);
    add_request(REQ_LOOKUP, 20'h12345, '0, '0);
    add_request(REQ_DELETE, 20'h00000, '0, '0);
    add_request(REQ_DELETE, 20'h00ABC, '0, '0);
    add_request(REQ_UNUSED, 20'hFFFFF, '0, '0);
    add_request(REQ_LOOKUP, 20'h00ABC, '0, '0);
    add_request(REQ_DELETE, 20'hFFFFF, '0, '0);
    add_request(REQ_DELETE, 20'h12345, '0, '0);
    add_request(REQ_INSERT, 20'h5A5A5, 64'h4B45_5954_4142_4C45, 10'h2AA);

    // random: fill past full, then drain, a few rounds
    for (int round = 0; round < 3; round++) begin
      for (int n = 0; n < 80; n++) add_random(90, 5, 3);
      for (int n = 0; n < 80; n++) add_random(10, 20, 65);
    end
    total_items = pending_reqs.size();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_reqs.size() == 0 && !in_valid);
    wait (expected_results.size() == 0);
    repeat (TB_DEPTH + 16) @(posedge clk);
    if (errors == 0) begin
      $display("** keyed_record_table: PASSED **");
    end else begin
      $display("** keyed_record_table: FAILED **");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/krt_pkg.sv
sv/krt_cell.sv
sv/krt_ctrl.sv
sv/keyed_record_table.sv
sv/krt_checker.sv
sim/tb_top.sv
